[hdl/dq_pkg.sv]
// Package for the double-ended queue: codes, defaults, field widths and control structs.
`timescale 1ns / 1ps

package dq_pkg;

  // Default geometry
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_LEFT  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_RIGHT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_LEFT   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_RIGHT  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_LEFT  = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_RIGHT = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic                take;     // request accepted this cycle
    logic                push;     // write one word at an end
    logic                rd;       // read the word at an end
    logic                pop;      // remove the word read
    logic                left;     // end select: 1 left, 0 right
    logic [STATUS_W-1:0] status;   // status code of this request
    logic                load_out; // load the result register
  } dq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dq_stat_t;

endpackage

[hdl/double_ended_queue.sv]
// Top level of the double-ended queue: stream ports, controller and datapath.
//
//   channel   direction  tdata fields (lowest bit up)                 width
//   s_axis    in         op[2:0], push_value[34:3], zero[39:35]       40
//   m_axis    out        data_out[31:0], status[33:32],               40
//                        empty_flag[34], occupancy[39:35]
//
// Each request is taken in S_IDLE, where the end pointers and fill count
// move and the ring store is read or written; in S_DONE it loads the
// result register. A new request is taken while a finished result still
// waits on m_axis; a stalled result holds the block in S_DONE.
// Reset clears the pointers, the fill count and all valids; the ring store
// is not cleared.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dq_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // op, push_value, zero pad
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dq_pkg::M_TDATA_W-1:0]   m_axis_tdata   // data_out, status, empty_flag, occupancy
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  logic [dq_pkg::OP_W-1:0]     op;
  logic [dq_pkg::WORD_W-1:0]   push_value;
  logic [dq_pkg::WORD_W-1:0]   data_out;
  logic [dq_pkg::STATUS_W-1:0] status;
  logic                        empty_flag;
  logic [dq_pkg::OCC_W-1:0]    occupancy;

  // Unpack the request
  assign op         = s_axis_tdata[dq_pkg::OP_W-1:0];
  assign push_value = s_axis_tdata[dq_pkg::OP_W +: dq_pkg::WORD_W];

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .op_i        (op),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .push_value_i (push_value),
    .data_out_o   (data_out),
    .status_o     (status),
    .empty_flag_o (empty_flag),
    .occupancy_o  (occupancy)
  );

  // Pack the result
  assign m_axis_tdata = {occupancy, empty_flag, status, data_out};

endmodule

[hdl/dq_ctrl.sv]
// Controller for the double-ended queue: request decode, sequencing and result valid.
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  logic [dq_pkg::OP_W-1:0] op_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  input  dq_pkg::dq_stat_t        stat_i,
  output dq_pkg::dq_cmd_t         cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic state_q, state_d;
  logic res_valid_q, res_valid_d;
  logic take;
  logic out_free;

  assign req_ready_o = (state_q == S_IDLE);
  assign take        = req_ready_o & req_valid_i;
  assign out_free    = ~res_valid_q | res_ready_i;
  assign res_valid_o = res_valid_q;

  // Decode the request against the current fill state
  always_comb begin
    cmd_o          = '0;
    cmd_o.take     = take;
    cmd_o.status   = dq_pkg::STATUS_OK;
    cmd_o.load_out = (state_q == S_DONE) & out_free;
    case (op_i)
      dq_pkg::OP_PUSH_LEFT, dq_pkg::OP_PUSH_RIGHT: begin
        cmd_o.left = (op_i == dq_pkg::OP_PUSH_LEFT);
        if (stat_i.full) begin
          cmd_o.status = dq_pkg::STATUS_FULL;
        end else begin
          cmd_o.push = take;
        end
      end
      dq_pkg::OP_POP_LEFT, dq_pkg::OP_POP_RIGHT,
      dq_pkg::OP_PEEK_LEFT, dq_pkg::OP_PEEK_RIGHT: begin
        cmd_o.left = (op_i == dq_pkg::OP_POP_LEFT) | (op_i == dq_pkg::OP_PEEK_LEFT);
        if (stat_i.empty) begin
          cmd_o.status = dq_pkg::STATUS_EMPTY;
        end else begin
          cmd_o.rd  = take;
          cmd_o.pop = take & ((op_i == dq_pkg::OP_POP_LEFT) | (op_i == dq_pkg::OP_POP_RIGHT));
        end
      end
      default: begin
        cmd_o.left = 1'b0;
      end
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result valid until the consumer takes it
  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_o.load_out) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

[hdl/dq_datapath.sv]
// Datapath for the double-ended queue: ring store, end pointers, fill count, result register.
`timescale 1ns / 1ps

module dq_datapath #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dq_pkg::dq_cmd_t               cmd_i,
  output dq_pkg::dq_stat_t              stat_o,
  input  logic [dq_pkg::WORD_W-1:0]     push_value_i,
  output logic [dq_pkg::WORD_W-1:0]     data_out_o,
  output logic [dq_pkg::STATUS_W-1:0]   status_o,
  output logic                          empty_flag_o,
  output logic [dq_pkg::OCC_W-1:0]      occupancy_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [IW-1:0] left_q, left_d;
  logic [IW-1:0] right_q, right_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] left_prev, left_next, right_prev, right_next;
  logic [IW-1:0] addr;

  logic [DATA_WIDTH-1:0]        mem_q [DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata_q;
  logic                         rd_ok_q;
  logic [dq_pkg::STATUS_W-1:0]  stat_code_q;

  logic [dq_pkg::WORD_W-1:0]   data_out_q;
  logic [dq_pkg::STATUS_W-1:0] status_q;
  logic                        empty_flag_q;
  logic [dq_pkg::OCC_W-1:0]    occupancy_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(DEPTH));

  // Neighbor positions on the ring
  assign left_prev  = (left_q == '0) ? IW'(DEPTH - 1) : left_q - IW'(1);
  assign left_next  = (left_q == IW'(DEPTH - 1)) ? '0 : left_q + IW'(1);
  assign right_prev = (right_q == '0) ? IW'(DEPTH - 1) : right_q - IW'(1);
  assign right_next = (right_q == IW'(DEPTH - 1)) ? '0 : right_q + IW'(1);

  // Select the one entry this request touches
  always_comb begin
    if (cmd_i.left) begin
      addr = cmd_i.push ? left_prev : left_q;
    end else begin
      addr = cmd_i.push ? right_q : right_prev;
    end
  end

  // Move the end pointers and the fill count
  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
      if (cmd_i.left) left_d = left_prev;
      else            right_d = right_next;
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      if (cmd_i.left) left_d = left_next;
      else            right_d = right_prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      count_q <= '0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
      count_q <= count_d;
    end
  end

  // Ring store with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[addr] <= DATA_WIDTH'(push_value_i);
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Capture the request outcome
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_ok_q     <= cmd_i.rd;
      stat_code_q <= cmd_i.status;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      data_out_q   <= rd_ok_q ? dq_pkg::WORD_W'(rdata_q) : '0;
      status_q     <= stat_code_q;
      empty_flag_q <= (count_q == '0);
      occupancy_q  <= dq_pkg::OCC_W'(count_q);
    end
  end

  assign data_out_o   = data_out_q;
  assign status_o     = status_q;
  assign empty_flag_o = empty_flag_q;
  assign occupancy_o  = occupancy_q;

endmodule

[hdl/dq_checker.sv]
// Port checker for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps

module dq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [dq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Take one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken in back-to-back cycles");

  // Empty flag matches a zero occupancy
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[34] == (m_axis_tdata[39:35] == '0)))
    else $error("empty flag disagrees with occupancy");

  // Empty status returns zero data and an empty deque
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33:32] == dq_pkg::STATUS_EMPTY
      |-> m_axis_tdata[31:0] == '0 && m_axis_tdata[34])
    else $error("empty status with data or entries");

  // Full status returns zero data and a nonempty deque
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33:32] == dq_pkg::STATUS_FULL
      |-> m_axis_tdata[31:0] == '0 && !m_axis_tdata[34])
    else $error("full status with data or no entries");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
